/* rtl/fir_smoothing_filter_assert.svh */
// assertion macros for the smoothing filter, clocked on clk, reset by arst_n
`ifndef FIR_SMOOTHING_FILTER_ASSERT_SVH
`define FIR_SMOOTHING_FILTER_ASSERT_SVH

// same-cycle implication
`define FSF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fsf assertion failed");

// next-cycle implication
`define FSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fsf assertion failed");

`endif

/* rtl/fsf_pkg.sv */
`default_nettype none

package fsf_pkg;

	localparam int TAP_COUNT        = 13;
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int TIME_WIDTH_DEF   = 32;

	localparam int TAP_HALF  = (TAP_COUNT - 1) / 2;
	localparam int TAP_LAST  = TAP_COUNT - 1;

	localparam int DIGIT_W   = 4;
	localparam int WEIGHT_W  = 27;
	localparam int DIV_W     = 30;
	localparam int PROD_W    = DIGIT_W + 1 + WEIGHT_W + 1;

	localparam logic [DIV_W-1:0] DIVISOR = DIV_W'(525454400);

	localparam int PAIR_W = 3;
	localparam logic [PAIR_W-1:0] PAIR_LAST = PAIR_W'(TAP_HALF);

	localparam int FILL_W = 4;
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAP_COUNT - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_STEP,
		ST_ACCUM,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DELIVER
	} fsf_state_t;

	typedef struct packed {
		logic shift;
		logic rotate;
	} win_ctrl_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic step;
		logic accum;
	} mac_ctrl_t;

	// weight shared by taps k and TAP_LAST-k
	function automatic logic [WEIGHT_W-1:0] pair_weight(input logic [PAIR_W-1:0] k);
		logic [WEIGHT_W-1:0] w;
		case (k)
			3'd0:    w = WEIGHT_W'(1687988);
			3'd1:    w = WEIGHT_W'(58749795);
			3'd2:    w = WEIGHT_W'(16299118);
			3'd3:    w = WEIGHT_W'(36044776);
			3'd4:    w = WEIGHT_W'(63539094);
			3'd5:    w = WEIGHT_W'(8928125);
			3'd6:    w = WEIGHT_W'(100000000);
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* rtl/fsf_sample_if.sv */
`default_nettype none

interface fsf_sample_if #(
	parameter int SAMPLE_WIDTH = fsf_pkg::SAMPLE_WIDTH_DEF,
	parameter int TIME_WIDTH   = fsf_pkg::TIME_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic        [TIME_WIDTH-1:0]   sample_time;
	logic signed [SAMPLE_WIDTH-1:0] sample_magnitude;

	modport source (output valid, output sample_time, output sample_magnitude, input ready);
	modport sink (input valid, input sample_time, input sample_magnitude, output ready);
endinterface

`default_nettype wire

/* rtl/fsf_smooth_if.sv */
`default_nettype none

interface fsf_smooth_if #(
	parameter int SAMPLE_WIDTH = fsf_pkg::SAMPLE_WIDTH_DEF,
	parameter int TIME_WIDTH   = fsf_pkg::TIME_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic        [TIME_WIDTH-1:0]   smooth_time;
	logic signed [SAMPLE_WIDTH-1:0] smooth_magnitude;

	modport source (output valid, output smooth_time, output smooth_magnitude, input ready);
	modport sink (input valid, input smooth_time, input smooth_magnitude, output ready);
endinterface

`default_nettype wire

/* rtl/fsf_window.sv */
`default_nettype none

module fsf_window #(
	parameter int SAMPLE_WIDTH = fsf_pkg::SAMPLE_WIDTH_DEF,
	parameter int TIME_WIDTH   = fsf_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire fsf_pkg::win_ctrl_t             ctrl,
	input  wire logic        [TIME_WIDTH-1:0]   new_time,
	input  wire logic signed [SAMPLE_WIDTH-1:0] new_mag,
	output logic signed      [SAMPLE_WIDTH-1:0] mag_lo,
	output logic signed      [SAMPLE_WIDTH-1:0] mag_hi,
	output logic signed      [SAMPLE_WIDTH-1:0] mag_mid,
	output logic             [TIME_WIDTH-1:0]   time_old
);
	localparam int HALF = fsf_pkg::TAP_HALF;
	localparam int LAST = fsf_pkg::TAP_LAST;

	logic signed [SAMPLE_WIDTH-1:0] mag_win_q  [fsf_pkg::TAP_COUNT];
	logic        [TIME_WIDTH-1:0]   time_win_q [fsf_pkg::TAP_COUNT];

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int i = 0; i < LAST; i++) begin
				mag_win_q[i]  <= mag_win_q[i+1];
				time_win_q[i] <= time_win_q[i+1];
			end
			mag_win_q[LAST]  <= new_mag;
			time_win_q[LAST] <= new_time;
		end else if (ctrl.rotate) begin
			// lower half turns toward slot 0, upper half toward the last slot
			for (int i = 0; i < HALF - 1; i++) begin
				mag_win_q[i] <= mag_win_q[i+1];
			end
			mag_win_q[HALF-1] <= mag_win_q[0];
			for (int i = HALF + 2; i <= LAST; i++) begin
				mag_win_q[i] <= mag_win_q[i-1];
			end
			mag_win_q[HALF+1] <= mag_win_q[LAST];
		end
	end

	assign mag_lo   = mag_win_q[0];
	assign mag_hi   = mag_win_q[LAST];
	assign mag_mid  = mag_win_q[HALF];
	assign time_old = time_win_q[0];

endmodule

`default_nettype wire

/* rtl/fsf_mac.sv */
`default_nettype none

module fsf_mac #(
	parameter int SAMPLE_WIDTH = fsf_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire fsf_pkg::mac_ctrl_t                 ctrl,
	input  wire logic        [fsf_pkg::PAIR_W-1:0]  pair,
	input  wire logic signed [SAMPLE_WIDTH-1:0]     mag_a,
	input  wire logic signed [SAMPLE_WIDTH-1:0]     mag_b,
	output logic signed      [SAMPLE_WIDTH+fsf_pkg::DIV_W-1:0] acc
);
	localparam int DW     = fsf_pkg::DIGIT_W;
	localparam int PW     = SAMPLE_WIDTH + 1;
	localparam int ND     = (PW + DW - 1) / DW;
	localparam int XW     = ND * DW;
	localparam int ACC_W  = SAMPLE_WIDTH + fsf_pkg::DIV_W;
	localparam int PROD_W = fsf_pkg::PROD_W;

	logic signed [PW-1:0]     pair_sum;
	logic        [XW-1:0]     pre_q;
	logic                     first_q;
	logic signed [ACC_W-1:0]  part_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic        [DW-1:0]     digit;
	logic signed [DW:0]       digit_s;
	logic signed [fsf_pkg::WEIGHT_W:0] weight_s;
	logic signed [PROD_W-1:0] prod;

	assign pair_sum = PW'(mag_a) + PW'(mag_b);
	assign digit    = pre_q[XW-1 -: DW];
	// top digit carries the sign
	assign digit_s  = $signed({first_q & digit[DW-1], digit});
	assign weight_s = $signed({1'b0, fsf_pkg::pair_weight(pair)});
	assign prod     = PROD_W'(digit_s) * PROD_W'(weight_s);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pre_q   <= XW'(pair_sum);
			first_q <= 1'b1;
			part_q  <= '0;
		end else if (ctrl.step) begin
			pre_q   <= pre_q << DW;
			first_q <= 1'b0;
			part_q  <= (part_q <<< DW) + ACC_W'(prod);
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.accum) begin
			acc_q <= acc_q + part_q;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

/* rtl/fsf_div.sv */
`default_nettype none

module fsf_div #(
	parameter int SAMPLE_WIDTH = fsf_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          start,
	input  wire logic signed [SAMPLE_WIDTH+fsf_pkg::DIV_W-1:0] dividend,
	output logic                                               busy,
	output logic                                               done,
	output logic signed      [SAMPLE_WIDTH-1:0]                quotient
);
	localparam int RW    = fsf_pkg::DIV_W;
	localparam int ACC_W = SAMPLE_WIDTH + RW;
	localparam int CW    = $clog2(SAMPLE_WIDTH);

	logic [ACC_W-1:0]        mag;
	logic [RW-1:0]           rem_q;
	logic [SAMPLE_WIDTH-1:0] quo_q;
	logic                    neg_q;
	logic [CW-1:0]           cnt_q;
	logic                    busy_q;
	logic [RW-1:0]           trial;
	logic                    fits;

	assign mag   = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
	assign trial = {rem_q[RW-2:0], quo_q[SAMPLE_WIDTH-1]};
	assign fits  = trial >= fsf_pkg::DIVISOR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ACC_W-1];
			rem_q <= mag[ACC_W-1 -: RW];
			quo_q <= mag[SAMPLE_WIDTH-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? (trial - fsf_pkg::DIVISOR) : trial;
			quo_q <= {quo_q[SAMPLE_WIDTH-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = busy_q && (cnt_q == CW'(SAMPLE_WIDTH - 1));
	assign quotient = neg_q ? $signed(~quo_q + SAMPLE_WIDTH'(1)) : $signed(quo_q);

endmodule

`default_nettype wire

/* rtl/fir_smoothing_filter.sv */
// a sample that fills the window runs through the digit-serial tap-pair multiply-accumulate, then
// the bit-serial divider, then the output register; ND = ceil((SAMPLE_WIDTH+1)/4) digits per pair sum
// no new sample is taken until that result is loaded into the output register; warm-up samples
// that do not yet fill the window are taken in idle with no computation
// reset: arst_n clears the sequencer, fill count and output valid; window contents are not reset
`default_nettype none
`include "fir_smoothing_filter_assert.svh"

module fir_smoothing_filter #(
	parameter int SAMPLE_WIDTH = fsf_pkg::SAMPLE_WIDTH_DEF,
	parameter int TIME_WIDTH   = fsf_pkg::TIME_WIDTH_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	fsf_sample_if.sink  sample,
	fsf_smooth_if.source smooth
);
	localparam int ND    = (SAMPLE_WIDTH + fsf_pkg::DIGIT_W) / fsf_pkg::DIGIT_W;
	localparam int DGW   = $clog2(ND);
	localparam int ACC_W = SAMPLE_WIDTH + fsf_pkg::DIV_W;

	fsf_pkg::fsf_state_t state_q, state_d;
	logic [fsf_pkg::PAIR_W-1:0] pair_q;
	logic [DGW-1:0]             dig_q;
	logic [fsf_pkg::FILL_W-1:0] fill_q;

	fsf_pkg::win_ctrl_t win_ctrl;
	fsf_pkg::mac_ctrl_t mac_ctrl;
	logic               div_start;
	logic               div_busy;
	logic               div_done;
	logic               out_load;
	logic               in_xfer;

	logic signed [SAMPLE_WIDTH-1:0] mag_lo, mag_hi, mag_mid, mac_a, mac_b;
	logic        [TIME_WIDTH-1:0]   time_old;
	logic signed [ACC_W-1:0]        acc;
	logic signed [SAMPLE_WIDTH-1:0] quotient;

	logic                           out_valid_q;
	logic        [TIME_WIDTH-1:0]   out_time_q;
	logic signed [SAMPLE_WIDTH-1:0] out_mag_q;

	assign in_xfer = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsf_pkg::ST_IDLE;
			pair_q  <= '0;
			dig_q   <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				pair_q <= '0;
				if (fill_q != fsf_pkg::FILL_FULL) begin
					fill_q <= fill_q + fsf_pkg::FILL_W'(1);
				end
			end
			if (state_q == fsf_pkg::ST_LOAD) begin
				dig_q <= '0;
			end else if (state_q == fsf_pkg::ST_STEP) begin
				dig_q <= dig_q + DGW'(1);
			end
			if (win_ctrl.rotate) begin
				pair_q <= pair_q + fsf_pkg::PAIR_W'(1);
			end
		end
	end

	always_comb begin
		state_d         = state_q;
		win_ctrl        = '0;
		mac_ctrl        = '0;
		div_start       = 1'b0;
		out_load        = 1'b0;
		sample.ready    = 1'b0;
		case (state_q)
			fsf_pkg::ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					win_ctrl.shift = 1'b1;
					if (fill_q == fsf_pkg::FILL_FULL) begin
						mac_ctrl.clear = 1'b1;
						state_d        = fsf_pkg::ST_LOAD;
					end
				end
			end
			fsf_pkg::ST_LOAD: begin
				mac_ctrl.load = 1'b1;
				state_d       = fsf_pkg::ST_STEP;
			end
			fsf_pkg::ST_STEP: begin
				mac_ctrl.step = 1'b1;
				if (dig_q == DGW'(ND - 1)) begin
					state_d = fsf_pkg::ST_ACCUM;
				end
			end
			fsf_pkg::ST_ACCUM: begin
				mac_ctrl.accum = 1'b1;
				if (pair_q == fsf_pkg::PAIR_LAST) begin
					state_d = fsf_pkg::ST_DIV_START;
				end else begin
					win_ctrl.rotate = 1'b1;
					state_d         = fsf_pkg::ST_LOAD;
				end
			end
			fsf_pkg::ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = fsf_pkg::ST_DIV_WAIT;
			end
			fsf_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = fsf_pkg::ST_DELIVER;
				end
			end
			fsf_pkg::ST_DELIVER: begin
				if (!out_valid_q || smooth.ready) begin
					out_load = 1'b1;
					state_d  = fsf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fsf_pkg::ST_IDLE;
			end
		endcase
	end

	// center tap has no partner
	assign mac_a = (pair_q == fsf_pkg::PAIR_LAST) ? mag_mid : mag_lo;
	assign mac_b = (pair_q == fsf_pkg::PAIR_LAST) ? '0 : mag_hi;

	fsf_window #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_window (
		.clk     (clk),
		.ctrl    (win_ctrl),
		.new_time(sample.sample_time),
		.new_mag (sample.sample_magnitude),
		.mag_lo  (mag_lo),
		.mag_hi  (mag_hi),
		.mag_mid (mag_mid),
		.time_old(time_old)
	);

	fsf_mac #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.pair (pair_q),
		.mag_a(mac_a),
		.mag_b(mac_b),
		.acc  (acc)
	);

	fsf_div #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(acc),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(quotient)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (smooth.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_time_q <= time_old;
			out_mag_q  <= quotient;
		end
	end

	assign smooth.valid            = out_valid_q;
	assign smooth.smooth_time      = out_time_q;
	assign smooth.smooth_magnitude = out_mag_q;

	`FSF_ASSERT_NEXT(a_full_starts_mac, in_xfer && fill_q == fsf_pkg::FILL_FULL, state_q == fsf_pkg::ST_LOAD)
	`FSF_ASSERT_NEXT(a_last_pair_divides, state_q == fsf_pkg::ST_ACCUM && pair_q == fsf_pkg::PAIR_LAST, state_q == fsf_pkg::ST_DIV_START)
	`FSF_ASSERT_SAME(a_wait_has_div, state_q == fsf_pkg::ST_DIV_WAIT, div_busy)
	`FSF_ASSERT_SAME(a_valid_from_deliver, $rose(out_valid_q), $past(state_q == fsf_pkg::ST_DELIVER))

endmodule

`default_nettype wire

/* bench/fsf_smooth_checker.sv */
`default_nettype none

module fsf_smooth_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	fsf_sample_if     samples,
	fsf_smooth_if     smoothed,
	output int        mismatch_count,
	output int        outstanding,
	output int        checked_count,
	output int        sample_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW   = fsf_pkg::SAMPLE_WIDTH_DEF;
	localparam int TW   = fsf_pkg::TIME_WIDTH_DEF;
	localparam int TAPS = fsf_pkg::TAP_COUNT;
	localparam int REPORT_LIMIT = 10;
	localparam longint FILTER_DIVISOR = 64'sd525454400;

	typedef struct packed {
		logic        [TW-1:0] stamp;
		logic signed [SW-1:0] mag;
	} timed_mag_t;

	longint tap_weights [TAPS] = '{
		1687988, 58749795, 16299118, 36044776, 63539094, 8928125, 100000000,
		8928125, 63539094, 36044776, 16299118, 58749795, 1687988
	};

	timed_mag_t sample_window [$];
	timed_mag_t smoothed_due [$];

	// weighted window sum, oldest first, truncated toward zero
	function automatic timed_mag_t smooth_window();
		longint     acc;
		timed_mag_t res;
		acc = 0;
		for (int k = 0; k < TAPS; k++)
			acc += longint'($signed(sample_window[k].mag)) * tap_weights[k];
		res.stamp = sample_window[0].stamp;
		res.mag   = SW'(acc / FILTER_DIVISOR);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timed_mag_t got;
		timed_mag_t want;
		timed_mag_t incoming;
		if (!arst_n) begin
			sample_window.delete();
			smoothed_due.delete();
			mismatch_count = 0;
			outstanding    = 0;
			checked_count  = 0;
			sample_count   = 0;
		end else begin
			if (smoothed.valid && smoothed.ready) begin
				got.stamp = smoothed.smooth_time;
				got.mag   = smoothed.smooth_magnitude;
				checked_count++;
				if (smoothed_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected smoothed result %0d: time %h magnitude %0d",
							checked_count, got.stamp, got.mag);
				end else begin
					want = smoothed_due.pop_front();
					if (got.stamp !== want.stamp || got.mag !== want.mag) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("smoothed result %0d: time exp %h got %h, magnitude exp %0d got %0d",
								checked_count, want.stamp, got.stamp, want.mag, got.mag);
					end
				end
			end
			if (samples.valid && samples.ready) begin
				incoming.stamp = samples.sample_time;
				incoming.mag   = samples.sample_magnitude;
				sample_count++;
				sample_window.push_back(incoming);
				if (sample_window.size() == TAPS) begin
					smoothed_due.push_back(smooth_window());
					void'(sample_window.pop_front());
				end
			end
			outstanding = smoothed_due.size();
		end
	end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = fsf_pkg::SAMPLE_WIDTH_DEF;
	localparam int TW = fsf_pkg::TIME_WIDTH_DEF;

	localparam int CYCLE_LIMIT     = 300000;
	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int DRAIN_CYCLES    = 120;
	localparam int PHASE_ITEMS     = 100;
	localparam int BACKLOG_ITEMS   = 24;

	localparam logic signed [SW-1:0] MAG_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] MAG_MIN = {1'b1, {(SW-1){1'b0}}};

	typedef enum int {
		PH_STEADY,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH_IDLE,
		PH_BACKLOG
	} idle_phase_t;

	typedef enum int {
		MAG_RANDOM,
		MAG_EXTREME,
		MAG_WALK,
		MAG_SMALL
	} mag_kind_t;

	logic clk;
	logic arst_n;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_requests;
	int holds_served;
	int cycle_count;

	int mismatch_count;
	int outstanding;
	int checked_count;
	int sample_count;

	logic        [TW-1:0] stamp;
	logic signed [SW-1:0] last_mag;

	fsf_sample_if sample_ch ();
	fsf_smooth_if smooth_ch ();

	fir_smoothing_filter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.smooth (smooth_ch)
	);

	fsf_smooth_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.samples        (sample_ch),
		.smoothed       (smooth_ch),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding),
		.checked_count  (checked_count),
		.sample_count   (sample_count)
	);

	always #5ns clk = ~clk;

	task automatic set_phase(input idle_phase_t ph);
		case (ph)
			PH_SEND_IDLE: begin
				send_idle_pct  = 47;
				recv_stall_pct = 0;
			end
			PH_RECV_STALL: begin
				send_idle_pct  = 0;
				recv_stall_pct = 47;
			end
			PH_BOTH_IDLE: begin
				send_idle_pct  = 15;
				recv_stall_pct = 15;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	task automatic send_sample(input logic [TW-1:0] t, input logic signed [SW-1:0] m);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid            <= 1'b1;
		sample_ch.sample_time      <= t;
		sample_ch.sample_magnitude <= m;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
	endtask

	function automatic logic signed [SW-1:0] pick_magnitude(input mag_kind_t kind,
		input logic signed [SW-1:0] prev);
		logic signed [SW-1:0] m;
		case (kind)
			MAG_EXTREME: begin
				case ($urandom_range(4))
					0:       m = MAG_MAX;
					1:       m = MAG_MIN;
					2:       m = '0;
					3:       m = '1;
					default: m = SW'(1);
				endcase
			end
			MAG_WALK:  m = prev + SW'(int'($urandom_range(4000)) - 2000);
			MAG_SMALL: m = SW'(int'($urandom_range(512)) - 256);
			default:   m = SW'($urandom);
		endcase
		return m;
	endfunction

	// runs of one kind of signal, timestamps mostly advancing with rare jumps
	task automatic send_random(input int count);
		mag_kind_t kind;
		kind = MAG_RANDOM;
		for (int n = 0; n < count; n++) begin
			if (n % 16 == 0)
				kind = mag_kind_t'($urandom_range(3));
			if ($urandom_range(15) == 0)
				stamp = TW'($urandom);
			else
				stamp = stamp + TW'($urandom_range(20, 1));
			last_mag = pick_magnitude(kind, last_mag);
			send_sample(stamp, last_mag);
		end
	endtask

	// output side, with a long hold-off on request
	initial begin
		holds_served = 0;
		smooth_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				smooth_ch.ready <= 1'b0;
				for (int c = 1; c < HOLD_OFF_CYCLES; c++)
					@(posedge clk);
			end else begin
				smooth_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cycle limit reached with %0d results outstanding", outstanding);
		$display("FAIL");
		$finish;
	end

	initial begin
		clk = 1'b0;
		hold_requests = 0;
		stamp         = '0;
		last_mag      = '0;
		set_phase(PH_STEADY);
		arst_n                     <= 1'b0;
		sample_ch.valid            <= 1'b0;
		sample_ch.sample_time      <= '0;
		sample_ch.sample_magnitude <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// warm-up at full scale, timestamps wrapping through all ones and zero
		for (int i = 0; i < 13; i++)
			send_sample({TW{1'b1}} - TW'(6) + TW'(i), MAG_MAX);
		for (int i = 0; i < 7; i++)
			send_sample(TW'(100 + i), MAG_MIN);
		send_sample(TW'(200), MAG_MAX);
		send_sample(TW'(201), MAG_MIN);
		send_sample(TW'(202), '0);
		send_sample(TW'(203), '1);
		send_sample({TW{1'b1}}, SW'(1));
		stamp = TW'(1000);

		set_phase(PH_SEND_IDLE);
		send_random(PHASE_ITEMS);
		set_phase(PH_RECV_STALL);
		send_random(PHASE_ITEMS);
		set_phase(PH_BACKLOG);
		hold_requests++;
		send_random(BACKLOG_ITEMS);
		set_phase(PH_BOTH_IDLE);
		send_random(PHASE_ITEMS);
		set_phase(PH_STEADY);
		send_random(PHASE_ITEMS);

		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d sample transfers in, %0d smoothed results compared", sample_count,
			checked_count);
		$display("covered warm-up, full-scale extremes, four idle mixes, %0d-cycle output hold-off",
			HOLD_OFF_CYCLES);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count, outstanding);
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
